// File: hw/rtl/assert_macros.svh
// Assertion helpers for the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check sampled on the rising clock edge, held off during reset
`define CHK_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// check sampled on every rising clock edge, reset included
`define CHK_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`endif

// File: hw/rtl/sttw_pkg.sv
package sttw_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int QA_W        = 2;
   localparam int EP_W        = 3;    // epoch mark on the channel count memory
   localparam int CHAN_Q_W    = 16;   // channel as carried through the queue
   localparam int CSR_ADDR_W  = 4;
   localparam int CSR_DATA_W  = 64;
   localparam logic [63:0] SPAN_RESET = 64'd1000;

   typedef enum logic [1:0] {
      OP_ADD     = 2'd0,
      OP_MOVE    = 2'd1,
      OP_RESTART = 2'd2,
      OP_CLEAR   = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      CMD_HIT,
      CMD_ADD,
      CMD_MOVE,
      CMD_RESTART,
      CMD_CLEAR
   } kind_type;

   typedef struct packed {
      kind_type              kind;
      logic [63:0]           tstamp;
      logic [31:0]           adc;
      logic [CHAN_Q_W-1:0]   chan;
   } cmd_type;

endpackage

// File: hw/rtl/sttw_ram.sv
module sttw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                  clock,
   input  logic                                  we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                      wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                      rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: hw/rtl/sttw_front.sv
module sttw_front #(
   parameter int NUM_CHANNELS = 4096
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_op,
   input  logic [63:0]         req_rec_start_time,
   input  logic [31:0]         req_rec_adc_sum,
   input  logic [11:0]         req_hit_chan,
   input  logic                req_hit_last,
   output logic                q_valid,
   output sttw_pkg::cmd_type   q_cmd,
   input  logic                q_pop
);

   sttw_pkg::cmd_type q_ff [sttw_pkg::QUEUE_DEPTH];
   logic [sttw_pkg::QA_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [sttw_pkg::QA_W:0]   cnt_ff, cnt_in;
   sttw_pkg::cmd_type cmd;
   logic push, pop;

   // channel modulo the channel count: eight conditional subtracts of shifted copies
   function automatic logic [sttw_pkg::CHAN_Q_W-1:0] chan_wrap(input logic [11:0] c);
      logic [31:0] w;
      w = {20'd0, c};
      for (int k = 7; k >= 0; k--) begin
         if (w >= (32'(NUM_CHANNELS) << k)) begin
            w = w - (32'(NUM_CHANNELS) << k);
         end
      end
      return sttw_pkg::CHAN_Q_W'(w);
   endfunction

   always_comb begin
      cmd.tstamp = req_rec_start_time;
      cmd.adc    = req_rec_adc_sum;
      cmd.chan   = chan_wrap(req_hit_chan);
      if (sttw_pkg::op_type'(req_op) == sttw_pkg::OP_CLEAR) begin
         cmd.kind = sttw_pkg::CMD_CLEAR;
      end else if (!req_hit_last) begin
         cmd.kind = sttw_pkg::CMD_HIT;
      end else begin
         unique case (sttw_pkg::op_type'(req_op))
            sttw_pkg::OP_ADD:  cmd.kind = sttw_pkg::CMD_ADD;
            sttw_pkg::OP_MOVE: cmd.kind = sttw_pkg::CMD_MOVE;
            default:           cmd.kind = sttw_pkg::CMD_RESTART;
         endcase
      end
   end

   assign req_stall = (cnt_ff == (sttw_pkg::QA_W+1)'(sttw_pkg::QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;
   assign q_valid   = (cnt_ff != '0);
   assign pop       = q_pop && q_valid;
   assign q_cmd     = q_ff[rd_ff];

   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + {{sttw_pkg::QA_W{1'b0}}, push} - {{sttw_pkg::QA_W{1'b0}}, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         q_ff[wr_ff] <= cmd;
      end
   end

endmodule

// File: hw/rtl/sttw_back.sv
module sttw_back #(
   parameter int MAX_RECORDS         = 64,
   parameter int MAX_HITS_PER_RECORD = 32,
   parameter int NUM_CHANNELS        = 4096
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  sttw_pkg::cmd_type   q_cmd,
   output logic                q_pop,
   input  logic [63:0]         span,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [63:0]         rsp_win_start,
   output logic [63:0]         rsp_win_newest,
   output logic [37:0]         rsp_adc_total,
   output logic [6:0]          rsp_rec_count,
   output logic [12:0]         rsp_chans_hit,
   output logic                rsp_dropped
);

   localparam int CNT_W = $clog2(MAX_RECORDS + 1);
   localparam int IDX_W = $clog2(MAX_RECORDS);
   localparam int HN_W  = $clog2(MAX_HITS_PER_RECORD + 1);
   localparam int HI_W  = (MAX_HITS_PER_RECORD > 1) ? $clog2(MAX_HITS_PER_RECORD) : 1;
   localparam int CH_W  = $clog2(NUM_CHANNELS);
   localparam int CC_W  = $clog2(MAX_RECORDS * MAX_HITS_PER_RECORD + 1);
   localparam int DC_W  = $clog2(NUM_CHANNELS + 1);
   localparam int EP_W  = sttw_pkg::EP_W;
   localparam int REC_W = 96 + HN_W + IDX_W;
   localparam int CW_W  = EP_W + CC_W;

   typedef enum logic [4:0] {
      S_CLR, S_IDLE, S_EXP_RD, S_EXP_CK, S_DN_RD, S_DN_CH, S_DN_WR,
      S_INS, S_ALLOC, S_SCAN_RD, S_SCAN_CK, S_SH_RD, S_SH_WR, S_PUT,
      S_UP_RD, S_UP_CH, S_UP_WR, S_FIN
   } state_type;

   state_type         state_ff, state_in, ret_ff, ret_in;
   sttw_pkg::cmd_type cmd_ff, cmd_in;
   logic [CNT_W-1:0]  held_ff, held_in, pos_ff, pos_in, j_ff, j_in;
   logic [CNT_W-1:0]  fcnt_ff, fcnt_in, virgin_ff, virgin_in;
   logic [IDX_W-1:0]  head_ff, head_in, id_ff, id_in;
   logic [IDX_W-1:0]  frd_ff, frd_in, fwr_ff, fwr_in;
   logic              from_free_ff, from_free_in;
   logic [63:0]       start_ff, start_in, newest_ff, newest_in;
   logic [37:0]       adc_ff, adc_in;
   logic [DC_W-1:0]   dist_ff, dist_in;
   logic              drop_ff, drop_in;
   logic [HN_W-1:0]   stage_n_ff, stage_n_in, hits_ff, hits_in, hi_ff, hi_in;
   logic [EP_W-1:0]   epoch_ff, epoch_in;
   logic [CH_W-1:0]   clr_ix_ff, clr_ix_in;
   logic              rsp_valid_ff, rsp_valid_in, rsp_dropped_ff, rsp_dropped_in;
   logic [63:0]       rsp_start_ff, rsp_start_in, rsp_newest_ff, rsp_newest_in;
   logic [37:0]       rsp_adc_ff, rsp_adc_in;
   logic [6:0]        rsp_count_ff, rsp_count_in;
   logic [12:0]       rsp_chans_ff, rsp_chans_in;

   // memory ports
   logic              rec_we, stg_we, chn_we, cnt_we, fre_we;
   logic [IDX_W-1:0]  rec_waddr, rec_raddr, fre_waddr, fre_raddr;
   logic [REC_W-1:0]  rec_wdata, rec_rdata;
   logic [HI_W-1:0]   stg_waddr, stg_raddr;
   logic [CH_W-1:0]   stg_wdata, stg_rdata, chn_wdata, chn_rdata;
   logic [IDX_W+HI_W-1:0] chn_waddr, chn_raddr;
   logic [CH_W-1:0]   cnt_waddr, cnt_raddr;
   logic [CW_W-1:0]   cnt_wdata, cnt_rdata;
   logic [IDX_W-1:0]  fre_wdata, fre_rdata;

   logic [63:0]       r_time;
   logic [31:0]       r_adc;
   logic [HN_W-1:0]   r_hits;
   logic [IDX_W-1:0]  r_id;
   logic [CC_W-1:0]   cnt_cur;
   logic              do_empty;
   state_type         empty_tgt;

   sttw_ram #(.WIDTH(REC_W), .DEPTH(MAX_RECORDS)) u_rec (
      .clock(clock), .we(rec_we), .waddr(rec_waddr), .wdata(rec_wdata),
      .raddr(rec_raddr), .rdata(rec_rdata));
   sttw_ram #(.WIDTH(CH_W), .DEPTH(MAX_HITS_PER_RECORD)) u_stage (
      .clock(clock), .we(stg_we), .waddr(stg_waddr), .wdata(stg_wdata),
      .raddr(stg_raddr), .rdata(stg_rdata));
   sttw_ram #(.WIDTH(CH_W), .DEPTH(MAX_RECORDS << HI_W)) u_chans (
      .clock(clock), .we(chn_we), .waddr(chn_waddr), .wdata(chn_wdata),
      .raddr(chn_raddr), .rdata(chn_rdata));
   sttw_ram #(.WIDTH(CW_W), .DEPTH(NUM_CHANNELS)) u_counts (
      .clock(clock), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
      .raddr(cnt_raddr), .rdata(cnt_rdata));
   sttw_ram #(.WIDTH(IDX_W), .DEPTH(MAX_RECORDS)) u_free (
      .clock(clock), .we(fre_we), .waddr(fre_waddr), .wdata(fre_wdata),
      .raddr(fre_raddr), .rdata(fre_rdata));

   // logical position to ring slot
   function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] hd,
                                             input logic [CNT_W-1:0] k);
      logic [CNT_W:0] s;
      s = (CNT_W+1)'(hd) + (CNT_W+1)'(k);
      if (s >= (CNT_W+1)'(MAX_RECORDS)) begin
         s = s - (CNT_W+1)'(MAX_RECORDS);
      end
      return IDX_W'(s);
   endfunction

   function automatic logic [IDX_W-1:0] ptr_inc(input logic [IDX_W-1:0] p);
      return (p == IDX_W'(MAX_RECORDS - 1)) ? '0 : p + 1'b1;
   endfunction

   assign r_time  = rec_rdata[REC_W-1 -: 64];
   assign r_adc   = rec_rdata[REC_W-65 -: 32];
   assign r_hits  = rec_rdata[IDX_W +: HN_W];
   assign r_id    = rec_rdata[IDX_W-1:0];
   // a count with a stale epoch was last touched before the window was emptied
   assign cnt_cur = (cnt_rdata[CC_W +: EP_W] == epoch_ff) ? cnt_rdata[CC_W-1:0] : '0;

   always_comb begin
      state_in = state_ff;  ret_in = ret_ff;  cmd_in = cmd_ff;
      held_in = held_ff;  pos_in = pos_ff;  j_in = j_ff;
      fcnt_in = fcnt_ff;  virgin_in = virgin_ff;  head_in = head_ff;  id_in = id_ff;
      frd_in = frd_ff;  fwr_in = fwr_ff;  from_free_in = from_free_ff;
      start_in = start_ff;  newest_in = newest_ff;  adc_in = adc_ff;  dist_in = dist_ff;
      drop_in = drop_ff;  stage_n_in = stage_n_ff;  hits_in = hits_ff;  hi_in = hi_ff;
      epoch_in = epoch_ff;  clr_ix_in = clr_ix_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_dropped_in = rsp_dropped_ff;  rsp_start_in = rsp_start_ff;
      rsp_newest_in = rsp_newest_ff;  rsp_adc_in = rsp_adc_ff;
      rsp_count_in = rsp_count_ff;  rsp_chans_in = rsp_chans_ff;
      q_pop = 1'b0;
      rec_we = 1'b0;  rec_waddr = '0;  rec_wdata = '0;  rec_raddr = '0;
      stg_we = 1'b0;  stg_waddr = '0;  stg_wdata = '0;  stg_raddr = '0;
      chn_we = 1'b0;  chn_waddr = '0;  chn_wdata = '0;  chn_raddr = '0;
      cnt_we = 1'b0;  cnt_waddr = '0;  cnt_wdata = '0;  cnt_raddr = '0;
      fre_we = 1'b0;  fre_waddr = '0;  fre_wdata = '0;  fre_raddr = '0;
      do_empty = 1'b0;  empty_tgt = S_IDLE;

      unique case (state_ff)
         S_CLR: begin
            cnt_we    = 1'b1;
            cnt_waddr = clr_ix_ff;
            cnt_wdata = {epoch_ff, {CC_W{1'b0}}};
            if (clr_ix_ff == CH_W'(NUM_CHANNELS - 1)) begin
               clr_ix_in = '0;
               state_in  = ret_ff;
            end else begin
               clr_ix_in = clr_ix_ff + 1'b1;
            end
         end
         S_IDLE: begin
            if (q_valid) begin
               q_pop  = 1'b1;
               cmd_in = q_cmd;
               if (q_cmd.kind == sttw_pkg::CMD_CLEAR) begin
                  do_empty   = 1'b1;
                  empty_tgt  = S_FIN;
                  start_in   = '0;
                  stage_n_in = '0;
                  drop_in    = 1'b0;
               end else begin
                  if (stage_n_ff < HN_W'(MAX_HITS_PER_RECORD)) begin
                     stg_we     = 1'b1;
                     stg_waddr  = stage_n_ff[HI_W-1:0];
                     stg_wdata  = q_cmd.chan[CH_W-1:0];
                     stage_n_in = stage_n_ff + 1'b1;
                  end else begin
                     drop_in = 1'b1;
                  end
                  case (q_cmd.kind)
                     sttw_pkg::CMD_ADD:  state_in = S_INS;
                     sttw_pkg::CMD_MOVE: state_in = S_EXP_RD;
                     sttw_pkg::CMD_RESTART: begin
                        do_empty  = 1'b1;
                        empty_tgt = S_INS;
                        start_in  = q_cmd.tstamp;
                     end
                     default: state_in = S_IDLE;
                  endcase
               end
            end
         end
         S_EXP_RD: begin
            if (held_ff == '0) begin
               do_empty  = 1'b1;
               empty_tgt = S_INS;
               start_in  = cmd_ff.tstamp;
            end else begin
               rec_raddr = head_ff;
               state_in  = S_EXP_CK;
            end
         end
         S_EXP_CK: begin
            if ((cmd_ff.tstamp - r_time) >= span) begin
               id_in     = r_id;
               hits_in   = r_hits;
               hi_in     = '0;
               adc_in    = adc_ff - 38'(r_adc);
               fre_we    = 1'b1;
               fre_waddr = fwr_ff;
               fre_wdata = r_id;
               fwr_in    = ptr_inc(fwr_ff);
               fcnt_in   = fcnt_ff + 1'b1;
               head_in   = ptr_inc(head_ff);
               held_in   = held_ff - 1'b1;
               state_in  = (r_hits == '0) ? S_EXP_RD : S_DN_RD;
            end else begin
               start_in = r_time;
               state_in = S_INS;
            end
         end
         S_DN_RD: begin
            chn_raddr = {id_ff, hi_ff[HI_W-1:0]};
            state_in  = S_DN_CH;
         end
         S_DN_CH: begin
            // keep the channel on the read port for the write-back cycle
            chn_raddr = {id_ff, hi_ff[HI_W-1:0]};
            cnt_raddr = chn_rdata;
            state_in  = S_DN_WR;
         end
         S_DN_WR: begin
            cnt_waddr = chn_rdata;
            if (cnt_cur != '0) begin
               cnt_we    = 1'b1;
               cnt_wdata = {epoch_ff, CC_W'(cnt_cur - 1'b1)};
               if (cnt_cur == CC_W'(1)) begin
                  dist_in = dist_ff - 1'b1;
               end
            end
            hi_in    = hi_ff + 1'b1;
            state_in = (HN_W'(hi_ff + 1'b1) == hits_ff) ? S_EXP_RD : S_DN_RD;
         end
         S_INS: begin
            if (held_ff >= CNT_W'(MAX_RECORDS)) begin
               drop_in  = 1'b1;
               state_in = S_FIN;
            end else begin
               if (fcnt_ff != '0) begin
                  fre_raddr    = frd_ff;
                  frd_in       = ptr_inc(frd_ff);
                  fcnt_in      = fcnt_ff - 1'b1;
                  from_free_in = 1'b1;
               end else begin
                  id_in        = virgin_ff[IDX_W-1:0];
                  virgin_in    = virgin_ff + 1'b1;
                  from_free_in = 1'b0;
               end
               state_in = S_ALLOC;
            end
         end
         S_ALLOC: begin
            if (from_free_ff) begin
               id_in = fre_rdata;
            end
            // held records stay sorted, so a time at or past the newest goes last
            if (held_ff == '0 || cmd_ff.tstamp >= newest_ff) begin
               pos_in   = held_ff;
               state_in = S_PUT;
            end else begin
               pos_in   = '0;
               state_in = S_SCAN_RD;
            end
         end
         S_SCAN_RD: begin
            rec_raddr = phys(head_ff, pos_ff);
            state_in  = S_SCAN_CK;
         end
         S_SCAN_CK: begin
            if (cmd_ff.tstamp < r_time) begin
               j_in     = held_ff;
               state_in = S_SH_RD;
            end else begin
               pos_in   = pos_ff + 1'b1;
               state_in = S_SCAN_RD;
            end
         end
         S_SH_RD: begin
            if (j_ff == pos_ff) begin
               state_in = S_PUT;
            end else begin
               rec_raddr = phys(head_ff, j_ff - 1'b1);
               state_in  = S_SH_WR;
            end
         end
         S_SH_WR: begin
            rec_we    = 1'b1;
            rec_waddr = phys(head_ff, j_ff);
            rec_wdata = rec_rdata;
            j_in      = j_ff - 1'b1;
            state_in  = S_SH_RD;
         end
         S_PUT: begin
            rec_we    = 1'b1;
            rec_waddr = phys(head_ff, pos_ff);
            rec_wdata = {cmd_ff.tstamp, cmd_ff.adc, stage_n_ff, id_ff};
            if (pos_ff == held_ff) begin
               newest_in = cmd_ff.tstamp;
            end
            adc_in   = adc_ff + 38'(cmd_ff.adc);
            held_in  = held_ff + 1'b1;
            hits_in  = stage_n_ff;
            hi_in    = '0;
            state_in = (stage_n_ff == '0) ? S_FIN : S_UP_RD;
         end
         S_UP_RD: begin
            stg_raddr = hi_ff[HI_W-1:0];
            state_in  = S_UP_CH;
         end
         S_UP_CH: begin
            // keep the staged channel on the read port for the write-back cycle
            stg_raddr = hi_ff[HI_W-1:0];
            chn_we    = 1'b1;
            chn_waddr = {id_ff, hi_ff[HI_W-1:0]};
            chn_wdata = stg_rdata;
            cnt_raddr = stg_rdata;
            state_in  = S_UP_WR;
         end
         S_UP_WR: begin
            cnt_we    = 1'b1;
            cnt_waddr = stg_rdata;
            cnt_wdata = {epoch_ff, CC_W'(cnt_cur + 1'b1)};
            if (cnt_cur == '0) begin
               dist_in = dist_ff + 1'b1;
            end
            hi_in    = hi_ff + 1'b1;
            state_in = (HN_W'(hi_ff + 1'b1) == hits_ff) ? S_FIN : S_UP_RD;
         end
         S_FIN: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in   = 1'b1;
               rsp_start_in   = start_ff;
               rsp_newest_in  = newest_ff;
               rsp_adc_in     = adc_ff;
               rsp_count_in   = 7'(held_ff);
               rsp_chans_in   = 13'(dist_ff);
               rsp_dropped_in = drop_ff;
               stage_n_in     = '0;
               drop_in        = 1'b0;
               state_in       = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (do_empty) begin
         held_in   = '0;
         head_in   = '0;
         adc_in    = '0;
         dist_in   = '0;
         newest_in = '0;
         fcnt_in   = '0;
         frd_in    = '0;
         fwr_in    = '0;
         virgin_in = '0;
         epoch_in  = epoch_ff + 1'b1;
         ret_in    = empty_tgt;
         // epoch wraps: sweep the counts so no stale mark can match again
         state_in  = (&epoch_ff) ? S_CLR : empty_tgt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         ret_ff       <= S_IDLE;
         held_ff      <= '0;
         head_ff      <= '0;
         fcnt_ff      <= '0;
         frd_ff       <= '0;
         fwr_ff       <= '0;
         virgin_ff    <= '0;
         start_ff     <= '0;
         newest_ff    <= '0;
         adc_ff       <= '0;
         dist_ff      <= '0;
         drop_ff      <= 1'b0;
         stage_n_ff   <= '0;
         epoch_ff     <= '0;
         clr_ix_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         held_ff      <= held_in;
         head_ff      <= head_in;
         fcnt_ff      <= fcnt_in;
         frd_ff       <= frd_in;
         fwr_ff       <= fwr_in;
         virgin_ff    <= virgin_in;
         start_ff     <= start_in;
         newest_ff    <= newest_in;
         adc_ff       <= adc_in;
         dist_ff      <= dist_in;
         drop_ff      <= drop_in;
         stage_n_ff   <= stage_n_in;
         epoch_ff     <= epoch_in;
         clr_ix_ff    <= clr_ix_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff         <= cmd_in;
      pos_ff         <= pos_in;
      j_ff           <= j_in;
      id_ff          <= id_in;
      from_free_ff   <= from_free_in;
      hits_ff        <= hits_in;
      hi_ff          <= hi_in;
      rsp_start_ff   <= rsp_start_in;
      rsp_newest_ff  <= rsp_newest_in;
      rsp_adc_ff     <= rsp_adc_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_chans_ff   <= rsp_chans_in;
      rsp_dropped_ff <= rsp_dropped_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_win_start  = rsp_start_ff;
   assign rsp_win_newest = rsp_newest_ff;
   assign rsp_adc_total  = rsp_adc_ff;
   assign rsp_rec_count  = rsp_count_ff;
   assign rsp_chans_hit  = rsp_chans_ff;
   assign rsp_dropped    = rsp_dropped_ff;

endmodule

// File: hw/rtl/sliding_time_window_hit_tracker.sv
// Channel  Direction  Handshake          Payload
// req      in         req_valid/stall    op, rec_start_time, rec_adc_sum, hit_chan, hit_last
// rsp      out        rsp_valid/stall    win_start, win_newest, adc_total, rec_count,
//                                        chans_hit, dropped
// csr      in         APB, pready high   window_span at byte address 0
//
// A hit item that is not last costs one cycle in the back end. A closing item costs
// about 5 (add, reset) or 7 (move) + 2 per expired record + 3 per expired hit + 2 per
// record scanned or moved (only for out-of-order times) + 3 per hit of the new record;
// clear takes 2.
// Reset starts a sweep of the channel count memory, NUM_CHANNELS cycles, during which
// items queue but are not worked; the same sweep follows every eighth window emptying.
// The four-entry queue takes items while the back end works or rsp is stalled.
module sliding_time_window_hit_tracker #(
   parameter int MAX_RECORDS         = 64,
   parameter int MAX_HITS_PER_RECORD = 32,
   parameter int NUM_CHANNELS        = 4096
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [1:0]                          req_op,
   input  logic [63:0]                         req_rec_start_time,
   input  logic [31:0]                         req_rec_adc_sum,
   input  logic [11:0]                         req_hit_chan,
   input  logic                                req_hit_last,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [63:0]                         rsp_win_start,
   output logic [63:0]                         rsp_win_newest,
   output logic [37:0]                         rsp_adc_total,
   output logic [6:0]                          rsp_rec_count,
   output logic [12:0]                         rsp_chans_hit,
   output logic                                rsp_dropped,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [sttw_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [sttw_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [sttw_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);

   logic [63:0]       span_ff, span_in;
   logic              q_valid, q_pop;
   sttw_pkg::cmd_type q_cmd;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[3] == 1'b0) ? span_ff : '0;

   always_comb begin
      span_in = span_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_paddr[3] == 1'b0) begin
         span_in = csr_pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         span_ff <= sttw_pkg::SPAN_RESET;
      end else begin
         span_ff <= span_in;
      end
   end

   sttw_front #(.NUM_CHANNELS(NUM_CHANNELS)) u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_op             (req_op),
      .req_rec_start_time (req_rec_start_time),
      .req_rec_adc_sum    (req_rec_adc_sum),
      .req_hit_chan       (req_hit_chan),
      .req_hit_last       (req_hit_last),
      .q_valid            (q_valid),
      .q_cmd              (q_cmd),
      .q_pop              (q_pop)
   );

   sttw_back #(
      .MAX_RECORDS         (MAX_RECORDS),
      .MAX_HITS_PER_RECORD (MAX_HITS_PER_RECORD),
      .NUM_CHANNELS        (NUM_CHANNELS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_valid),
      .q_cmd          (q_cmd),
      .q_pop          (q_pop),
      .span           (span_ff),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_win_start  (rsp_win_start),
      .rsp_win_newest (rsp_win_newest),
      .rsp_adc_total  (rsp_adc_total),
      .rsp_rec_count  (rsp_rec_count),
      .rsp_chans_hit  (rsp_chans_hit),
      .rsp_dropped    (rsp_dropped)
   );

endmodule

// File: hw/rtl/sttw_checker.sv
`include "assert_macros.svh"

module sttw_checker #(
   parameter int MAX_RECORDS = 64
) (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [63:0] rsp_win_start,
   input logic [63:0] rsp_win_newest,
   input logic [37:0] rsp_adc_total,
   input logic [6:0]  rsp_rec_count,
   input logic [12:0] rsp_chans_hit,
   input logic        rsp_dropped,
   input logic        csr_pready
);

   // a stalled result holds
   `CHK_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_win_start) && $stable(rsp_adc_total) && $stable(rsp_rec_count) && $stable(rsp_dropped))

   `CHK_ASSERT(a_count_bound, clock, reset, rsp_valid |-> MAX_RECORDS > 127 || rsp_rec_count <= 7'(MAX_RECORDS))

   // an empty window has no ADC, no newest time and no channel with hits
   `CHK_ASSERT(a_empty_window, clock, reset, rsp_valid && rsp_rec_count == 7'd0 && MAX_RECORDS < 128 |-> rsp_win_newest == 64'd0 && rsp_adc_total == 38'd0 && rsp_chans_hit == 13'd0)

   `CHK_ASSERT_ALWAYS(a_pready, clock, csr_pready)

endmodule

bind sliding_time_window_hit_tracker sttw_checker #(.MAX_RECORDS(MAX_RECORDS)) u_sttw_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_win_start  (rsp_win_start),
   .rsp_win_newest (rsp_win_newest),
   .rsp_adc_total  (rsp_adc_total),
   .rsp_rec_count  (rsp_rec_count),
   .rsp_chans_hit  (rsp_chans_hit),
   .rsp_dropped    (rsp_dropped),
   .csr_pready     (csr_pready)
);
